// ----- src/stc_pkg.sv -----
// Shared types, codes and helpers for the scalar type converter.
// No dependencies; the core and stc_convert refer to this package by scoped names.
package stc_pkg;

  typedef enum logic [2:0] {
    MODE_INVALID = 3'd0,
    MODE_CHAR    = 3'd1,
    MODE_INT     = 3'd2,
    MODE_FLOAT   = 3'd3,
    MODE_DOUBLE  = 3'd4
  } stc_mode_e;

  localparam logic [7:0]  PRINT_LOW  = 8'h20;
  localparam logic [7:0]  PRINT_HIGH = 8'h7E;
  localparam logic [31:0] CHAR_TOP   = 32'd127;

  typedef struct packed {
    logic [7:0]  char_value;
    logic [31:0] int_value;
    logic [31:0] float_bits;
    logic [63:0] double_bits;
    logic        all_impossible;
    logic        int_impossible;
    logic        char_impossible;
    logic        char_nonprintable;
  } stc_res_t;

  // leading zero count; an all-zero word wraps to 0 and is caught by callers
  function automatic logic [4:0] lzc32(logic [31:0] v);
    logic [4:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else      n = n + 5'd1;
      end
    end
    return n;
  endfunction

endpackage

// ----- src/stc_if.sv -----
// Channel interfaces: valid/ready handshake with the converter payload.
// Depends on nothing.
interface stc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] source_bits;
  modport source (output valid, mode, source_bits, input ready);
  modport sink   (input valid, mode, source_bits, output ready);
endinterface

interface stc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_value;
  logic signed [31:0] int_value;
  logic [31:0] float_bits;
  logic [63:0] double_bits;
  logic        all_impossible;
  logic        int_impossible;
  logic        char_impossible;
  logic        char_nonprintable;
  modport source (output valid, char_value, int_value, float_bits, double_bits,
                  all_impossible, int_impossible, char_impossible, char_nonprintable,
                  input ready);
  modport sink   (input valid, char_value, int_value, float_bits, double_bits,
                  all_impossible, int_impossible, char_impossible, char_nonprintable,
                  output ready);
endinterface

// ----- src/scalar_type_converter_core.sv -----
// Top level of the scalar type converter: input register, conversion, result register.
// Depends on stc_pkg, stc_if and stc_convert.
//
// One scalar tagged invalid, char, int32, binary32 or binary64 goes in; all four
// forms plus impossibility flags come out. An input transfer lands in the input
// register, and the conversion result is captured in the result register once
// that register is free, from where it is offered to the sink. A new item is
// taken every cycle while the sink keeps up. The input stage takes a transfer
// when it is empty or its item moves into the result register; a stalled result
// with a full input stage holds off the input. Narrowing rounds to nearest even;
// float-to-int truncates toward zero.
module scalar_type_converter_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  stc_in_if.sink          in_i,
  stc_out_if.source       out_o
);

  logic              in_vld_q;
  logic [2:0]        mode_q;
  logic [63:0]       src_q;
  logic              out_vld_q;
  stc_pkg::stc_res_t res_d, res_q;
  logic              out_adv;

  // result register frees when empty or when its transfer completes
  assign out_adv    = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q  <= in_i.valid;
      if (out_adv)    out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      mode_q <= in_i.mode;
      src_q  <= in_i.source_bits;
    end
    if (out_adv && in_vld_q) res_q <= res_d;
  end

  stc_convert u_convert (
    .mode_i        (mode_q),
    .source_bits_i (src_q),
    .res_o         (res_d)
  );

  assign out_o.valid             = out_vld_q;
  assign out_o.char_value        = res_q.char_value;
  assign out_o.int_value         = res_q.int_value;
  assign out_o.float_bits        = res_q.float_bits;
  assign out_o.double_bits       = res_q.double_bits;
  assign out_o.all_impossible    = res_q.all_impossible;
  assign out_o.int_impossible    = res_q.int_impossible;
  assign out_o.char_impossible   = res_q.char_impossible;
  assign out_o.char_nonprintable = res_q.char_nonprintable;

endmodule

// ----- src/stc_convert.sv -----
// Combinational conversion of one tagged scalar into all four forms.
// Depends on stc_pkg.
module stc_convert (
  input  logic [2:0]       mode_i,
  input  logic [63:0]      source_bits_i,
  output stc_pkg::stc_res_t res_o
);

  // integer source
  logic [31:0] w, mag, nrm;
  logic [4:0]  lz;
  logic        isgn, irnd;
  logic [30:0] ibits;
  logic [31:0] fb_int;
  logic [63:0] db_int;
  // binary32 source
  logic [7:0]  fe;
  logic [22:0] ff;
  logic [4:0]  lz2;
  logic [31:0] n2;
  logic [63:0] db_flt;
  // binary64 source
  logic [10:0] de, ee;
  logic [51:0] df;
  logic [52:0] m53;
  logic signed [12:0] fn, tsh;
  logic [5:0]  sh;
  logic [7:0]  base;
  logic [116:0] ext;
  logic [23:0] q;
  logic        grd, stk, drnd;
  logic [30:0] dbits;
  logic [31:0] fb_dbl;
  // truncation
  logic [63:0] db_src;
  logic [10:0] te;
  logic [52:0] tm;
  logic [5:0]  tsft;
  logic [31:0] ip, lim, iv_tr;
  logic        tfrac, ii_tr;
  logic [31:0] iv, fb;
  logic [63:0] db;
  logic        all, ii;
  logic [7:0]  cv;

  // signed integer to binary32 / binary64
  always_comb begin
    w      = (stc_pkg::stc_mode_e'(mode_i) == stc_pkg::MODE_CHAR)
             ? {{24{source_bits_i[7]}}, source_bits_i[7:0]} : source_bits_i[31:0];
    isgn   = w[31];
    mag    = isgn ? (32'd0 - w) : w;
    lz     = stc_pkg::lzc32(mag);
    nrm    = mag << lz;
    irnd   = nrm[7] & ((|nrm[6:0]) | nrm[8]);
    ibits  = {8'(8'd158 - {3'b0, lz}), nrm[30:8]} + {30'd0, irnd};
    fb_int = (mag == '0) ? '0 : {isgn, ibits};
    db_int = (mag == '0) ? '0 : {isgn, 11'(11'd1054 - {6'b0, lz}), nrm[30:0], 21'd0};
  end

  // binary32 widening, exact
  always_comb begin
    fe  = source_bits_i[30:23];
    ff  = source_bits_i[22:0];
    lz2 = stc_pkg::lzc32({9'd0, ff});
    n2  = {9'd0, ff} << lz2;
    if (fe == 8'hFF) begin
      // NaN comes out quiet
      db_flt = {source_bits_i[31], 11'h7FF, {ff, 29'd0} | {(ff != '0), 51'd0}};
    end else if (fe == '0) begin
      if (ff == '0) db_flt = {source_bits_i[31], 63'd0};
      else db_flt = {source_bits_i[31], 11'(11'd905 - {6'b0, lz2}), n2[30:0], 21'd0};
    end else begin
      db_flt = {source_bits_i[31], 11'({3'b0, fe} + 11'd896), ff, 29'd0};
    end
  end

  // binary64 narrowing, round to nearest even, subnormals kept
  always_comb begin
    de   = source_bits_i[62:52];
    df   = source_bits_i[51:0];
    m53  = {(de != '0), df};
    ee   = (de == '0) ? 11'd1 : de;
    fn   = $signed({2'b0, ee}) - 13'sd896;
    tsh  = 13'sd30 - fn;
    if (fn >= 13'sd1) begin
      sh   = 6'd29;
      base = 8'(fn - 13'sd1);
    end else begin
      sh   = (tsh > 13'sd63) ? 6'd63 : tsh[5:0];
      base = '0;
    end
    ext   = {m53, 64'd0} >> sh;
    q     = ext[87:64];
    grd   = ext[63];
    stk   = |ext[62:0];
    drnd  = grd & (stk | q[0]);
    dbits = {base, 23'd0} + {7'd0, q} + {30'd0, drnd};
    if (de == 11'h7FF) begin
      fb_dbl = {source_bits_i[63], 8'hFF, df[51:29] | {(df != '0), 22'd0}};
    end else if (m53 == '0) begin
      fb_dbl = {source_bits_i[63], 31'd0};
    end else if (fn >= 13'sd255 || dbits >= 31'h7F80_0000) begin
      fb_dbl = {source_bits_i[63], 8'hFF, 23'd0};
    end else begin
      fb_dbl = {source_bits_i[63], dbits};
    end
  end

  // truncation toward zero, from the exact binary64 form of either float source
  always_comb begin
    db_src = (stc_pkg::stc_mode_e'(mode_i) == stc_pkg::MODE_FLOAT) ? db_flt : source_bits_i;
    te     = db_src[62:52];
    tm     = {1'b1, db_src[51:0]};
    tsft   = 6'(11'd1075 - te);
    ip     = 32'(tm >> tsft);
    tfrac  = (tm & ((53'd1 << tsft) - 53'd1)) != '0;
    lim    = db_src[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    ii_tr  = 1'b0;
    iv_tr  = '0;
    if (te == 11'h7FF || te >= 11'd1055) begin
      ii_tr = 1'b1;
    end else if (te >= 11'd1023) begin
      if (ip > lim || (ip == lim && tfrac)) ii_tr = 1'b1;
      else iv_tr = db_src[63] ? (32'd0 - ip) : ip;
    end
  end

  always_comb begin
    all = 1'b0;
    ii  = 1'b0;
    iv  = '0;
    fb  = '0;
    db  = '0;
    unique case (stc_pkg::stc_mode_e'(mode_i))
      stc_pkg::MODE_CHAR, stc_pkg::MODE_INT: begin
        iv = w;
        fb = fb_int;
        db = db_int;
      end
      stc_pkg::MODE_FLOAT: begin
        iv = iv_tr;
        ii = ii_tr;
        fb = source_bits_i[31:0];
        db = db_flt;
      end
      stc_pkg::MODE_DOUBLE: begin
        iv = iv_tr;
        ii = ii_tr;
        fb = fb_dbl;
        db = source_bits_i;
      end
      default: begin
        all = 1'b1;
        ii  = 1'b1;
      end
    endcase
    cv = ii ? 8'd0 : iv[7:0];
    res_o.char_value        = cv;
    res_o.int_value         = iv;
    res_o.float_bits        = fb;
    res_o.double_bits       = db;
    res_o.all_impossible    = all;
    res_o.int_impossible    = ii;
    res_o.char_impossible   = ii || (iv > stc_pkg::CHAR_TOP);
    res_o.char_nonprintable = (cv < stc_pkg::PRINT_LOW) || (cv > stc_pkg::PRINT_HIGH);
  end

endmodule

// ----- src/stc_checker.sv -----
// Port-level checks on the converter result channel, bound to the top level.
// Depends on scalar_type_converter_core.
module stc_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [7:0]  char_value_i,
  input logic [31:0] int_value_i,
  input logic        all_impossible_i,
  input logic        int_impossible_i,
  input logic        char_impossible_i,
  input logic        char_nonprintable_i
);

  a_invalid_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && all_impossible_i |-> int_impossible_i && char_impossible_i
      && char_nonprintable_i && int_value_i == '0)
    else $error("invalid source not flagged throughout");

  a_int_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && int_impossible_i |-> int_value_i == '0 && char_value_i == '0
      && char_impossible_i)
    else $error("impossible int carries a value");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !char_impossible_i |-> int_value_i[31:7] == '0
      && char_value_i == int_value_i[7:0])
    else $error("char not flagged outside 0..127");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(int_value_i) && $stable(char_value_i))
    else $error("stalled result changed");

endmodule

bind scalar_type_converter_core stc_port_checker u_stc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .valid_i             (out_o.valid),
  .ready_i             (out_o.ready),
  .char_value_i        (out_o.char_value),
  .int_value_i         (out_o.int_value),
  .all_impossible_i    (out_o.all_impossible),
  .int_impossible_i    (out_o.int_impossible),
  .char_impossible_i   (out_o.char_impossible),
  .char_nonprintable_i (out_o.char_nonprintable)
);
